// ===== rtl/linear_blend_vertex_skinning_top_macros.svh =====
// Assertion macros shared by the skinning block.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_TOP_MACROS_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_TOP_MACROS_SVH

// A property checked at every rising edge outside reset.
`define LBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define LBS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// Types, codes and helpers shared by the skinning pipeline.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int WORDS = 12;
  localparam int SLOTS = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SKIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BONES_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FLOOR = 4'd1;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [15:0] nq_t;

  typedef struct packed {
    logic           skin;
    fx_t [2:0]      pos;
    nq_t [2:0]      nrm;
  } vtx_t;

  typedef struct packed {
    fx_t [2:0]      pos;
    nq_t [2:0]      nrm;
    logic           skin;
  } res_t;

  function automatic fx_t sat32(input logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -64'sh8000_0000) begin
      return -32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

// ===== rtl/lbs_if.sv =====
// ----------------------------------------------------------------------------
// lbs_if
// Valid/ready channels of the skinning block: vertex and load items in,
// skinned vertices out, and the register write channel.
// ----------------------------------------------------------------------------
interface lbs_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [5:0]         palette_bone;
  logic [3:0]         palette_word;
  logic signed [31:0] palette_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [31:0]        bone_ids;
  logic [63:0]        bone_weights;

  modport source (output valid, mode, palette_bone, palette_word, palette_value,
                  pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, bone_ids,
                  bone_weights, input ready);
  modport sink (input valid, mode, palette_bone, palette_word, palette_value,
                pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, bone_ids,
                bone_weights, output ready);
endinterface

interface lbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [15:0] out_norm_x;
  logic signed [15:0] out_norm_y;
  logic signed [15:0] out_norm_z;
  logic               was_skinned;

  modport source (output valid, out_x, out_y, out_z, out_norm_x, out_norm_y,
                  out_norm_z, was_skinned, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_norm_x, out_norm_y,
                out_norm_z, was_skinned, output ready);
endinterface

interface lbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lbs_palette.sv =====
// ----------------------------------------------------------------------------
// lbs_palette
// Bone palette memories and the first pipeline stage: reads the matrices of
// every influence, masks skipped influences and compares the total weight.
// ----------------------------------------------------------------------------
module lbs_palette import lbs_pkg::*; #(
  parameter int PALETTE_BONES = 64,
  parameter int N_INFL        = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               load_i,
  input  logic               vtx_valid_i,
  input  logic [5:0]         palette_bone_i,
  input  logic [3:0]         palette_word_i,
  input  logic [31:0]        palette_value_i,
  input  logic [31:0]        bone_ids_i,
  input  logic [63:0]        bone_weights_i,
  input  vtx_t               vtx_i,
  input  logic [6:0]         bones_in_use_i,
  input  logic [15:0]        weight_floor_i,
  output logic               valid_o,
  output vtx_t               vtx_o,
  output logic [15:0]        wts_o [N_INFL],
  output logic signed [31:0] words_o [N_INFL][WORDS]
);

  localparam int BW = (PALETTE_BONES > 1) ? $clog2(PALETTE_BONES) : 1;
  localparam logic [8:0] NBONES = 9'(PALETTE_BONES);

  logic [7:0]  bone8;
  logic        wr_ok;
  logic [15:0] wm [N_INFL];
  logic [17:0] total;

  assign bone8 = {2'b00, palette_bone_i};
  assign wr_ok = load_i && ({1'b0, bone8} < NBONES) && (palette_word_i < 4'(WORDS));

  // Each influence has its own copy of every matrix word, so the matrices
  // of all influences are read in the same cycle.
  for (genvar i = 0; i < N_INFL; i++) begin : g_infl
    logic [7:0] id;
    assign id = bone_ids_i[8*i +: 8];
    for (genvar k = 0; k < WORDS; k++) begin : g_word
      logic [31:0] mem [PALETTE_BONES];
      always_ff @(posedge clk_i) begin
        if (wr_ok && (palette_word_i == 4'(k))) begin
          mem[bone8[BW-1:0]] <= palette_value_i;
        end
        if (adv_i) begin
          words_o[i][k] <= mem[id[BW-1:0]];
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < N_INFL; i++) begin
      if ((bone_weights_i[16*i +: 16] != 16'd0) &&
          (bone_ids_i[8*i +: 8] < {1'b0, bones_in_use_i}) &&
          ({1'b0, bone_ids_i[8*i +: 8]} < NBONES)) begin
        wm[i] = bone_weights_i[16*i +: 16];
      end else begin
        wm[i] = 16'd0;
      end
      total = total + 18'(wm[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= vtx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vtx_t v;
    if (adv_i) begin
      v      = vtx_i;
      v.skin = total > {2'b00, weight_floor_i};
      vtx_o  <= v;
      for (int i = 0; i < N_INFL; i++) begin
        wts_o[i] <= wm[i];
      end
    end
  end

endmodule

// ===== rtl/lbs_blend.sv =====
// ----------------------------------------------------------------------------
// lbs_blend
// Weights the bone matrices and sums them into one rounded, saturated
// s15.16 matrix: a multiply stage and an add stage.
// ----------------------------------------------------------------------------
module lbs_blend import lbs_pkg::*; #(
  parameter int N_INFL = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  vtx_t               vtx_i,
  input  logic [15:0]        wts_i [N_INFL],
  input  logic signed [31:0] words_i [N_INFL][WORDS],
  output logic               valid_o,
  output vtx_t               vtx_o,
  output fx_t                m_o [WORDS]
);

  logic               p_valid_q;
  vtx_t               p_vtx_q;
  logic signed [48:0] prod_q [N_INFL][WORDS];
  fx_t                m_d [WORDS];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_vtx_q <= vtx_i;
      for (int i = 0; i < N_INFL; i++) begin
        for (int k = 0; k < WORDS; k++) begin
          prod_q[i][k] <= $signed({1'b0, wts_i[i]}) * words_i[i][k];
        end
      end
    end
  end

  always_comb begin
    logic signed [50:0] acc;
    for (int k = 0; k < WORDS; k++) begin
      acc = 51'sd32768;
      for (int i = 0; i < N_INFL; i++) begin
        acc = acc + 51'(prod_q[i][k]);
      end
      m_d[k] = sat32(64'(acc >>> 16));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (adv_i) begin
      p_valid_q <= valid_i;
      valid_o   <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vtx_o <= p_vtx_q;
      m_o   <= m_d;
    end
  end

endmodule

// ===== rtl/lbs_xform.sv =====
// ----------------------------------------------------------------------------
// lbs_xform
// Applies the blended matrix to the position and the normal: a multiply
// stage, then the row sums with rounding and saturation of the position.
// ----------------------------------------------------------------------------
module lbs_xform import lbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  vtx_t               vtx_i,
  input  fx_t                m_i [WORDS],
  output logic               valid_o,
  output vtx_t               vtx_o,
  output fx_t                pos_o [3],
  output logic signed [49:0] v_o [3]
);

  logic               p_valid_q;
  vtx_t               p_vtx_q;
  logic signed [63:0] pm_q [3][3];
  logic signed [47:0] nm_q [3][3];
  fx_t                t_q [3];
  fx_t                pos_d [3];
  logic signed [49:0] v_d [3];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_vtx_q <= vtx_i;
      for (int r = 0; r < 3; r++) begin
        t_q[r] <= m_i[r*4 + 3];
        for (int c = 0; c < 3; c++) begin
          pm_q[r][c] <= m_i[r*4 + c] * $signed(vtx_i.pos[c]);
          nm_q[r][c] <= m_i[r*4 + c] * $signed(vtx_i.nrm[c]);
        end
      end
    end
  end

  always_comb begin
    logic signed [63:0] p;
    logic signed [49:0] v;
    for (int r = 0; r < 3; r++) begin
      p = 64'(t_q[r]);
      v = '0;
      for (int c = 0; c < 3; c++) begin
        p = p + ((pm_q[r][c] + 64'sd32768) >>> 16);
        v = v + 50'(nm_q[r][c]);
      end
      pos_d[r] = sat32(p);
      v_d[r]   = v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (adv_i) begin
      p_valid_q <= valid_i;
      valid_o   <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vtx_o <= p_vtx_q;
      pos_o <= pos_d;
      v_o   <= v_d;
    end
  end

endmodule

// ===== rtl/lbs_norm.sv =====
// ----------------------------------------------------------------------------
// lbs_norm
// Renormalises the transformed normal: magnitude scaling, sum of squares,
// a pipelined square root and three pipelined dividers, then the output
// register of the block.
// ----------------------------------------------------------------------------
`include "linear_blend_vertex_skinning_top_macros.svh"

module lbs_norm import lbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  vtx_t               vtx_i,
  input  fx_t                pos_i [3],
  input  logic signed [49:0] v_i [3],
  output logic               valid_o,
  output res_t               res_o
);

  localparam int SQ_ST = 16;  // two root bits per stage
  localparam int DV_ST = 5;   // three quotient bits per stage

  typedef struct packed {
    vtx_t            vtx;
    fx_t [2:0]       pos;
    logic [2:0]      neg;
    logic            zero;
    logic [2:0][30:0] sm;
  } side_t;

  // Stage 1: magnitudes and their OR, which has the MSB of the largest.
  logic        v1_q;
  side_t       s1_q;
  logic [49:0] mag1_q [3];
  logic [49:0] or1_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q.vtx  <= vtx_i;
      s1_q.pos  <= {pos_i[2], pos_i[1], pos_i[0]};
      s1_q.zero <= 1'b0;
      s1_q.sm   <= '0;
      for (int i = 0; i < 3; i++) begin
        s1_q.neg[i] <= v_i[i][49];
        mag1_q[i]   <= v_i[i][49] ? 50'(-v_i[i]) : 50'(v_i[i]);
      end
      or1_q <= (v_i[0][49] ? 50'(-v_i[0]) : 50'(v_i[0])) |
               (v_i[1][49] ? 50'(-v_i[1]) : 50'(v_i[1])) |
               (v_i[2][49] ? 50'(-v_i[2]) : 50'(v_i[2]));
    end
  end

  // Stage 2: leading one within each byte.
  logic       v2_q;
  side_t      s2_q;
  logic [49:0] mag2_q [3];
  logic [6:0] gnz_q;
  logic [2:0] gmsb_q [7];

  always_ff @(posedge clk_i) begin
    logic [55:0] o56;
    logic [2:0]  sub;
    if (adv_i) begin
      o56 = {6'b0, or1_q};
      for (int g = 0; g < 7; g++) begin
        sub = 3'd0;
        for (int b = 0; b < 8; b++) begin
          if (o56[8*g + b]) sub = 3'(b);
        end
        gnz_q[g]  <= |o56[8*g +: 8];
        gmsb_q[g] <= sub;
      end
      s2_q   <= s1_q;
      mag2_q <= mag1_q;
    end
  end

  // Stage 3: leading one of the whole word.
  logic       v3_q;
  side_t      s3_q;
  logic [49:0] mag3_q [3];
  logic [5:0] msb3_q;

  always_ff @(posedge clk_i) begin
    logic [5:0] msb;
    side_t      s3;
    if (adv_i) begin
      msb = 6'd0;
      for (int g = 0; g < 7; g++) begin
        if (gnz_q[g]) msb = 6'(8*g) + {3'b000, gmsb_q[g]};
      end
      s3        = s2_q;
      s3.zero   = ~|gnz_q;
      msb3_q    <= msb;
      s3_q      <= s3;
      mag3_q    <= mag2_q;
    end
  end

  // Stage 4: scale so that the largest magnitude lies in [2^30, 2^31).
  logic  v4_q;
  side_t s4_q;

  always_ff @(posedge clk_i) begin
    side_t s4;
    if (adv_i) begin
      s4 = s3_q;
      for (int i = 0; i < 3; i++) begin
        if (msb3_q >= 6'd30) begin
          s4.sm[i] = 31'(mag3_q[i] >> (msb3_q - 6'd30));
        end else begin
          s4.sm[i] = 31'(mag3_q[i] << (6'd30 - msb3_q));
        end
      end
      s4_q <= s4;
    end
  end

  // Stage 5: squares. Stage 6: their sum.
  logic        v5_q;
  side_t       s5_q;
  logic [61:0] sqp5_q [3];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s5_q <= s4_q;
      for (int i = 0; i < 3; i++) begin
        sqp5_q[i] <= 62'(s4_q.sm[i]) * 62'(s4_q.sm[i]);
      end
    end
  end

  logic        sv_q [SQ_ST+1];
  side_t       ss_q [SQ_ST+1];
  logic [63:0] sx_q [SQ_ST+1];
  logic [63:0] sr_q [SQ_ST+1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ss_q[0] <= s5_q;
      sx_q[0] <= 64'(sqp5_q[0]) + 64'(sqp5_q[1]) + 64'(sqp5_q[2]);
      sr_q[0] <= 64'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      sv_q[0] <= 1'b0;
    end else if (adv_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      sv_q[0] <= v5_q;
    end
  end

  // Integer square root, digit by digit, two result bits per stage.
  for (genvar s = 0; s < SQ_ST; s++) begin : g_sqrt
    logic [63:0] x_d;
    logic [63:0] r_d;

    always_comb begin
      logic [63:0] b;
      logic [64:0] t;
      x_d = sx_q[s];
      r_d = sr_q[s];
      for (int j = 0; j < 2; j++) begin
        b = 64'd1 << (62 - 4*s - 2*j);
        t = {1'b0, r_d} + {1'b0, b};
        if ({1'b0, x_d} >= t) begin
          x_d = x_d - t[63:0];
          r_d = (r_d >> 1) + b;
        end else begin
          r_d = r_d >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        sv_q[s+1] <= sv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ss_q[s+1] <= ss_q[s];
        sx_q[s+1] <= x_d;
        sr_q[s+1] <= r_d;
      end
    end
  end

  // Divider set-up: numerator = mag * 2^14 + len / 2. Its top bits stay
  // below len because no magnitude exceeds the length.
  logic        dv_q [DV_ST+1];
  side_t       ds_q [DV_ST+1];
  logic [31:0] dlen_q [DV_ST+1];
  logic [31:0] drm_q [DV_ST+1][3];
  logic [14:0] dlo_q [DV_ST+1][3];
  logic [14:0] dq_q [DV_ST+1][3];

  always_ff @(posedge clk_i) begin
    logic [45:0] num;
    if (adv_i) begin
      ds_q[0]   <= ss_q[SQ_ST];
      dlen_q[0] <= sr_q[SQ_ST][31:0];
      for (int i = 0; i < 3; i++) begin
        num = (46'(ss_q[SQ_ST].sm[i]) << 14) + 46'(sr_q[SQ_ST][31:1]);
        drm_q[0][i] <= 32'(num[45:15]);
        dlo_q[0][i] <= num[14:0];
        dq_q[0][i]  <= 15'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (adv_i) begin
      dv_q[0] <= sv_q[SQ_ST];
    end
  end

  for (genvar s = 0; s < DV_ST; s++) begin : g_div
    logic [31:0] rm_d [3];
    logic [14:0] q_d [3];

    always_comb begin
      logic [32:0] t;
      for (int i = 0; i < 3; i++) begin
        rm_d[i] = drm_q[s][i];
        q_d[i]  = dq_q[s][i];
        for (int j = 0; j < 3; j++) begin
          t = {rm_d[i], dlo_q[s][i][14 - 3*s - j]};
          if (t >= {1'b0, dlen_q[s]}) begin
            t = t - {1'b0, dlen_q[s]};
            q_d[i][14 - 3*s - j] = 1'b1;
          end
          rm_d[i] = t[31:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        dv_q[s+1] <= dv_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ds_q[s+1]   <= ds_q[s];
        dlen_q[s+1] <= dlen_q[s];
        drm_q[s+1]  <= rm_d;
        dlo_q[s+1]  <= dlo_q[s];
        dq_q[s+1]   <= q_d;
      end
    end
  end

  // Output register. Items at or below the weight floor leave as they came.
  always_ff @(posedge clk_i) begin
    side_t sd;
    if (adv_i) begin
      sd         = ds_q[DV_ST];
      res_o.skin <= sd.vtx.skin;
      for (int i = 0; i < 3; i++) begin
        if (!sd.vtx.skin) begin
          res_o.pos[i] <= sd.vtx.pos[i];
          res_o.nrm[i] <= sd.vtx.nrm[i];
        end else begin
          res_o.pos[i] <= sd.pos[i];
          if (sd.zero) begin
            res_o.nrm[i] <= 16'sd0;
          end else if (sd.neg[i]) begin
            res_o.nrm[i] <= -$signed({1'b0, dq_q[DV_ST][i]});
          end else begin
            res_o.nrm[i] <= $signed({1'b0, dq_q[DV_ST][i]});
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= dv_q[DV_ST];
    end
  end

  `LBS_ASSERT(a_unit_normal, clk_i, rst_ni, (valid_o && res_o.skin) |-> ($signed(res_o.nrm[0]) <= 16'sd16384 && $signed(res_o.nrm[0]) >= -16'sd16384 && $signed(res_o.nrm[1]) <= 16'sd16384 && $signed(res_o.nrm[1]) >= -16'sd16384 && $signed(res_o.nrm[2]) <= 16'sd16384 && $signed(res_o.nrm[2]) >= -16'sd16384), "renormalised normal component out of range")
  `LBS_ASSERT_NEXT(a_sqrt_moves, clk_i, rst_ni, adv_i && sv_q[0], sv_q[1], "item lost entering the square root")
  `LBS_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, !adv_i, $stable(valid_o) && $stable(res_o), "result changed during a stall")

endmodule

// ===== rtl/linear_blend_vertex_skinning_top.sv =====
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_top
// Four-influence linear blend skinning with a bone palette in local memory.
// ----------------------------------------------------------------------------
// The block takes one item per clock for as long as the consumer takes the
// results; while a result waits on the output the whole pipeline holds, the
// input included. A vertex item passes through the palette read, the matrix
// blend, the transform and the normal unit, whose sixteen-stage square root
// and five-stage dividers set the depth. A load item writes one palette word
// at once and gives no result; a vertex accepted in the very next cycle
// already sees it. The palette needs no clearing after reset, so items are
// taken from the first cycle; bones must be loaded before a vertex uses them.
// The user must write registers only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_top import lbs_pkg::*; #(
  parameter int PALETTE_BONES = 64,
  parameter int INFLUENCES    = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbs_in_if.sink    in_i,
  lbs_out_if.source out_o,
  lbs_cfg_if.sink   cfg_i
);

  localparam int N_INFL = (INFLUENCES < SLOTS) ? INFLUENCES : SLOTS;

  logic        adv;
  logic        acc;
  logic [6:0]  bones_in_use_q;
  logic [15:0] weight_floor_q;
  vtx_t        vin;

  logic               pal_valid;
  vtx_t               pal_vtx;
  logic [15:0]        wts [N_INFL];
  logic signed [31:0] words [N_INFL][WORDS];

  logic blend_valid;
  vtx_t blend_vtx;
  fx_t  m [WORDS];

  logic               xf_valid;
  vtx_t               xf_vtx;
  fx_t                xf_pos [3];
  logic signed [49:0] xf_v [3];

  logic res_valid;
  res_t res;

  // The whole pipeline moves together; the output register frees it.
  assign adv        = !res_valid || out_o.ready;
  assign in_i.ready = adv;
  assign acc        = in_i.valid && adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bones_in_use_q <= 7'd0;
      weight_floor_q <= 16'd7;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BONES_IN_USE: bones_in_use_q <= cfg_i.data[6:0];
        CFG_WEIGHT_FLOOR: weight_floor_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    vin.skin   = 1'b0;
    vin.pos[0] = in_i.pos_x;
    vin.pos[1] = in_i.pos_y;
    vin.pos[2] = in_i.pos_z;
    vin.nrm[0] = in_i.norm_x;
    vin.nrm[1] = in_i.norm_y;
    vin.nrm[2] = in_i.norm_z;
  end

  lbs_palette #(
    .PALETTE_BONES (PALETTE_BONES),
    .N_INFL        (N_INFL)
  ) u_palette (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .load_i          (acc && (in_i.mode == MODE_LOAD)),
    .vtx_valid_i     (acc && (in_i.mode == MODE_SKIN)),
    .palette_bone_i  (in_i.palette_bone),
    .palette_word_i  (in_i.palette_word),
    .palette_value_i (in_i.palette_value),
    .bone_ids_i      (in_i.bone_ids),
    .bone_weights_i  (in_i.bone_weights),
    .vtx_i           (vin),
    .bones_in_use_i  (bones_in_use_q),
    .weight_floor_i  (weight_floor_q),
    .valid_o         (pal_valid),
    .vtx_o           (pal_vtx),
    .wts_o           (wts),
    .words_o         (words)
  );

  lbs_blend #(
    .N_INFL (N_INFL)
  ) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (pal_valid),
    .vtx_i   (pal_vtx),
    .wts_i   (wts),
    .words_i (words),
    .valid_o (blend_valid),
    .vtx_o   (blend_vtx),
    .m_o     (m)
  );

  lbs_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (blend_valid),
    .vtx_i   (blend_vtx),
    .m_i     (m),
    .valid_o (xf_valid),
    .vtx_o   (xf_vtx),
    .pos_o   (xf_pos),
    .v_o     (xf_v)
  );

  lbs_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (xf_valid),
    .vtx_i   (xf_vtx),
    .pos_i   (xf_pos),
    .v_i     (xf_v),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign out_o.valid       = res_valid;
  assign out_o.out_x       = res.pos[0];
  assign out_o.out_y       = res.pos[1];
  assign out_o.out_z       = res.pos[2];
  assign out_o.out_norm_x  = res.nrm[0];
  assign out_o.out_norm_y  = res.nrm[1];
  assign out_o.out_norm_z  = res.nrm[2];
  assign out_o.was_skinned = res.skin;

endmodule
